// File: sv/notch_slot_tracker_assert.svh
// Assertion macros for the notch slot tracker checkers
`ifndef NOTCH_SLOT_TRACKER_ASSERT_SVH
`define NOTCH_SLOT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nst_pkg.sv
// Types, codes and helpers shared by the notch slot tracker
package nst_pkg;

  localparam int FREQ_W  = 15;
  localparam int DELTA_W = 10;
  localparam int IDX_W   = 4;
  localparam int Q_W     = 9;
  localparam int DEPTH_W = 14;
  localparam int HOLD_W  = 18;
  localparam int HOUT_W  = 17;
  localparam int MAG_W   = 13;
  localparam int PROD_W  = MAG_W + DELTA_W;
  localparam int MAX_REPORTS = 8;

  localparam logic [1:0] CMD_DETECT = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [3:0] EV_REFRESHED = 4'd0;
  localparam logic [3:0] EV_FIXED     = 4'd1;
  localparam logic [3:0] EV_NEW       = 4'd2;
  localparam logic [3:0] EV_REPLACED  = 4'd3;
  localparam logic [3:0] EV_HOLDING   = 4'd4;
  localparam logic [3:0] EV_RELEASING = 4'd5;
  localparam logic [3:0] EV_RELEASED  = 4'd6;
  localparam logic [3:0] EV_IDLE      = 4'd7;
  localparam logic [3:0] EV_SET       = 4'd8;
  localparam logic [3:0] EV_CLEARED   = 4'd9;
  localparam logic [3:0] EV_REJECTED  = 4'd10;

  localparam logic [2:0] REG_DEPTH   = 3'd0;
  localparam logic [2:0] REG_HOLD    = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_Q       = 3'd3;
  localparam logic [2:0] REG_MAXDYN  = 3'd4;

  localparam logic signed [DEPTH_W-1:0] DEPTH_LO = -14'sd6144;
  localparam logic signed [DEPTH_W-1:0] DEPTH_HI = -14'sd1536;
  localparam logic [15:0] MS_LO = 16'd100;
  localparam logic [Q_W-1:0] Q_LO = 9'd80;
  localparam logic [Q_W-1:0] Q_HI = 9'd288;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] notch_depth;
    logic [15:0]               hold_ms;
    logic [15:0]               release_ms;
    logic [Q_W-1:0]            notch_q;
    logic [3:0]                max_dynamic;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [FREQ_W-1:0] freq;
  } fix_word_t;

  typedef struct packed {
    logic                      act;
    logic [FREQ_W-1:0]         freq;
    logic [Q_W-1:0]            q;
    logic signed [DEPTH_W-1:0] depth;
    logic signed [HOLD_W-1:0]  hold;
  } dyn_word_t;

  function automatic logic near_freq(input logic [FREQ_W-1:0] a,
                                     input logic [FREQ_W-1:0] f);
    logic [FREQ_W-1:0] d;
    d = (a > f) ? (a - f) : (f - a);
    return (22'(d) * 22'd100) < (22'(a) * 22'd3);
  endfunction

endpackage

// File: sv/notch_slot_tracker.sv
// Notch slot tracker top level: slot memories, sequencer and stream ports
//
// channel   | direction | handshake          | payload
// s_*       | in        | s_tvalid/s_tready  | s_tuser command, s_tdata freq/delta/index
// m_*       | out       | m_tvalid/m_tready  | m_tuser event, m_tdata slot fields, m_tlast
// apb       | in/out    | psel/penable       | paddr, pwdata, prdata, pready
//
// One transaction at a time. Detect: each fixed slot is read and compared, then each
// dynamic slot, then one result is sent. Tick: the release step unit runs, then each
// dynamic slot is read, updated and written back, with a result for each of the first
// MAX_REPORTS slots. Set: write, then result; clear: read, write, then result.
// Synchronous reset clears valid bits so every slot reads as zero.
// A stalled m_tready holds the sequencer.
module notch_slot_tracker
  import nst_pkg::*;
#(
  parameter int NUM_FIXED   = 4,
  parameter int NUM_DYNAMIC = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // frequency_hz, delta_ms, slot_index
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // slot, active, frequency_out, q_out, depth_out, hold_out
  output logic [3:0]  m_tuser,   // event_res
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int FIW = (NUM_FIXED > 1) ? $clog2(NUM_FIXED) : 1;
  localparam int DIW = (NUM_DYNAMIC > 1) ? $clog2(NUM_DYNAMIC) : 1;
  localparam int LAST_REP = ((NUM_DYNAMIC < MAX_REPORTS) ? NUM_DYNAMIC : MAX_REPORTS) - 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FRD  = 4'd1;
  localparam logic [3:0] ST_FEV  = 4'd2;
  localparam logic [3:0] ST_DRD  = 4'd3;
  localparam logic [3:0] ST_DEV  = 4'd4;
  localparam logic [3:0] ST_CRD  = 4'd5;
  localparam logic [3:0] ST_CEV  = 4'd6;
  localparam logic [3:0] ST_SET  = 4'd7;
  localparam logic [3:0] ST_TDIV = 4'd8;
  localparam logic [3:0] ST_TRD  = 4'd9;
  localparam logic [3:0] ST_TEV  = 4'd10;
  localparam logic [3:0] ST_SEND = 4'd11;

  cfg_t cfg;

  logic [3:0]          state;
  logic [3:0]          after;
  logic [FREQ_W-1:0]   freq_r;
  logic [DELTA_W-1:0]  delta_r;
  logic [FIW-1:0]      fcnt;
  logic [DIW-1:0]      dcnt;
  logic                found_free;
  logic [DIW-1:0]      free_idx;
  logic [DIW-1:0]      min_idx;
  logic signed [HOLD_W-1:0] min_hold;
  logic [PROD_W-1:0]   step;

  logic [3:0]          o_slot;
  logic [3:0]          o_ev;
  logic                o_act;
  logic [FREQ_W-1:0]   o_freq;
  logic [Q_W-1:0]      o_q;
  logic [DEPTH_W-1:0]  o_depth;
  logic [HOUT_W-1:0]   o_hold;
  logic                o_last;

  logic [NUM_FIXED-1:0]   fix_vld;
  logic [NUM_DYNAMIC-1:0] dyn_vld;
  logic                   fix_rvld;
  logic                   dyn_rvld;
  fix_word_t              fix_rdata;
  fix_word_t              fw;
  fix_word_t              fix_wdata;
  logic                   fix_we;
  dyn_word_t              dyn_rdata;
  dyn_word_t              dw;
  dyn_word_t              dyn_wdata;
  logic                   dyn_we;
  logic [DIW-1:0]         dyn_waddr;

  logic                   s_fire;
  logic                   div_start;
  logic                   div_done;
  logic [PROD_W-1:0]      div_quo;

  logic                   d_match;
  logic                   d_inlim;
  logic                   d_last;
  logic                   c_free;
  logic [DIW-1:0]         c_free_idx;
  logic [DIW-1:0]         c_min_idx;
  logic signed [HOLD_W-1:0] c_min_hold;
  logic [DIW-1:0]         alloc_idx;
  logic signed [HOLD_W-1:0] new_hold;
  dyn_word_t              tw;
  logic [3:0]             t_ev;
  logic signed [PROD_W:0] t_sum;
  logic                   in_range;
  logic [3:0]             dyn_slot;

  nst_cfg #(.NUM_DYNAMIC(NUM_DYNAMIC)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  nst_ram #(.WIDTH($bits(fix_word_t)), .DEPTH(NUM_FIXED)) u_fix_ram (
    .clk, .we(fix_we), .waddr(fcnt), .wdata(fix_wdata), .raddr(fcnt), .rdata(fix_rdata)
  );

  nst_ram #(.WIDTH($bits(dyn_word_t)), .DEPTH(NUM_DYNAMIC)) u_dyn_ram (
    .clk, .we(dyn_we), .waddr(dyn_waddr), .wdata(dyn_wdata), .raddr(dcnt),
    .rdata(dyn_rdata)
  );

  nst_div u_div (
    .clk, .rst, .start(div_start), .mag(MAG_W'(-cfg.notch_depth)), .delta(delta_r),
    .den(cfg.release_ms), .done(div_done), .quo(div_quo)
  );

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign m_tvalid  = (state == ST_SEND);
  assign m_tdata   = {4'd0, o_hold, o_depth, o_q, o_freq, o_act, o_slot};
  assign m_tuser   = o_ev;
  assign m_tlast   = o_last;
  assign div_start = (state == ST_TDIV) && !div_done && (after == ST_IDLE);

  assign fw = fix_rvld ? fix_rdata : '0;
  assign dw = dyn_rvld ? dyn_rdata : '0;

  assign in_range = {1'b0, s_tdata[28:25]} < 5'(NUM_FIXED);
  assign dyn_slot = 4'(NUM_FIXED) + 4'(dcnt);
  assign new_hold = HOLD_W'(cfg.hold_ms);

  always_comb begin
    d_match    = dw.act && near_freq(dw.freq, freq_r);
    d_inlim    = 6'(dcnt) < 6'(cfg.max_dynamic);
    d_last     = dcnt == DIW'(NUM_DYNAMIC - 1);
    c_free     = found_free || (!dw.act && d_inlim);
    c_free_idx = found_free ? free_idx : dcnt;
    c_min_idx  = min_idx;
    c_min_hold = min_hold;
    if ((dcnt == '0) || (d_inlim && (dw.hold < min_hold))) begin
      c_min_idx  = dcnt;
      c_min_hold = dw.hold;
    end
    alloc_idx = c_free ? c_free_idx : c_min_idx;

    tw    = dw;
    t_ev  = EV_IDLE;
    t_sum = (PROD_W+1)'(dw.depth) + $signed({1'b0, step});
    if (dw.act) begin
      if (dw.hold > 0) begin
        tw.hold = dw.hold - HOLD_W'(delta_r);
        t_ev    = EV_HOLDING;
      end else begin
        t_ev = EV_RELEASING;
        if (dw.depth < 0) begin
          if (!t_sum[PROD_W]) begin
            tw.depth = '0;
            tw.act   = 1'b0;
            t_ev     = EV_RELEASED;
          end else begin
            tw.depth = DEPTH_W'(t_sum);
          end
        end
      end
    end
  end

  always_comb begin
    fix_we    = 1'b0;
    fix_wdata = '0;
    dyn_we    = 1'b0;
    dyn_waddr = dcnt;
    dyn_wdata = '0;
    case (state)
      ST_SET: begin
        fix_we    = 1'b1;
        fix_wdata = '{en: 1'b1, freq: freq_r};
      end
      ST_CEV: begin
        fix_we    = 1'b1;
        fix_wdata = '{en: 1'b0, freq: fw.freq};
      end
      ST_DEV: begin
        if (d_match) begin
          dyn_we    = 1'b1;
          dyn_wdata = '{act: 1'b1, freq: dw.freq, q: dw.q,
                        depth: cfg.notch_depth, hold: new_hold};
        end else if (d_last) begin
          dyn_we    = 1'b1;
          dyn_waddr = alloc_idx;
          dyn_wdata = '{act: 1'b1, freq: freq_r, q: cfg.notch_q,
                        depth: cfg.notch_depth, hold: new_hold};
        end
      end
      ST_TEV: begin
        dyn_we    = 1'b1;
        dyn_wdata = tw;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fix_rvld <= fix_vld[fcnt];
    dyn_rvld <= dyn_vld[dcnt];
    if (rst) begin
      state   <= ST_IDLE;
      after   <= ST_IDLE;
      fix_vld <= '0;
      dyn_vld <= '0;
      fcnt    <= '0;
      dcnt    <= '0;
    end else begin
      if (fix_we) fix_vld[fcnt] <= 1'b1;
      if (dyn_we) dyn_vld[dyn_waddr] <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          after <= ST_IDLE;
          if (s_fire) begin
            freq_r  <= s_tdata[14:0];
            delta_r <= s_tdata[24:15];
            unique case (s_tuser)
              CMD_DETECT: begin
                fcnt       <= '0;
                dcnt       <= '0;
                found_free <= 1'b0;
                state      <= ST_FRD;
              end
              CMD_TICK: state <= ST_TDIV;
              default: begin
                if (!in_range) begin
                  o_slot  <= s_tdata[28:25];
                  o_ev    <= EV_REJECTED;
                  o_act   <= 1'b0;
                  o_freq  <= '0;
                  o_q     <= '0;
                  o_depth <= '0;
                  o_hold  <= '0;
                  o_last  <= 1'b1;
                  state   <= ST_SEND;
                end else begin
                  fcnt  <= s_tdata[25 +: FIW];
                  state <= (s_tuser == CMD_SET) ? ST_SET : ST_CRD;
                end
              end
            endcase
          end
        end
        ST_FRD: state <= ST_FEV;
        ST_FEV: begin
          if (fw.en && near_freq(fw.freq, freq_r)) begin
            o_slot  <= 4'(fcnt);
            o_ev    <= EV_FIXED;
            o_act   <= 1'b1;
            o_freq  <= fw.freq;
            o_q     <= '0;
            o_depth <= '0;
            o_hold  <= '0;
            o_last  <= 1'b1;
            state   <= ST_SEND;
          end else if (fcnt == FIW'(NUM_FIXED - 1)) begin
            state <= ST_DRD;
          end else begin
            fcnt  <= fcnt + 1'b1;
            state <= ST_FRD;
          end
        end
        ST_DRD: state <= ST_DEV;
        ST_DEV: begin
          found_free <= c_free;
          free_idx   <= c_free_idx;
          min_idx    <= c_min_idx;
          min_hold   <= c_min_hold;
          o_last     <= 1'b1;
          o_act      <= 1'b1;
          o_depth    <= cfg.notch_depth;
          o_hold     <= HOUT_W'(new_hold);
          if (d_match) begin
            o_slot <= dyn_slot;
            o_ev   <= EV_REFRESHED;
            o_freq <= dw.freq;
            o_q    <= dw.q;
            state  <= ST_SEND;
          end else if (d_last) begin
            o_slot <= 4'(NUM_FIXED) + 4'(alloc_idx);
            o_ev   <= c_free ? EV_NEW : EV_REPLACED;
            o_freq <= freq_r;
            o_q    <= cfg.notch_q;
            state  <= ST_SEND;
          end else begin
            dcnt  <= dcnt + 1'b1;
            state <= ST_DRD;
          end
        end
        ST_SET: begin
          o_slot  <= 4'(fcnt);
          o_ev    <= EV_SET;
          o_act   <= 1'b1;
          o_freq  <= freq_r;
          o_q     <= '0;
          o_depth <= '0;
          o_hold  <= '0;
          o_last  <= 1'b1;
          state   <= ST_SEND;
        end
        ST_CRD: state <= ST_CEV;
        ST_CEV: begin
          o_slot  <= 4'(fcnt);
          o_ev    <= EV_CLEARED;
          o_act   <= 1'b0;
          o_freq  <= fw.freq;
          o_q     <= '0;
          o_depth <= '0;
          o_hold  <= '0;
          o_last  <= 1'b1;
          state   <= ST_SEND;
        end
        ST_TDIV: begin
          after <= ST_TRD;
          if (div_done) begin
            step  <= div_quo;
            dcnt  <= '0;
            state <= ST_TRD;
          end
        end
        ST_TRD: state <= ST_TEV;
        ST_TEV: begin
          o_slot  <= dyn_slot;
          o_ev    <= t_ev;
          o_act   <= tw.act;
          o_freq  <= tw.freq;
          o_q     <= tw.q;
          o_depth <= tw.depth;
          o_hold  <= HOUT_W'(tw.hold);
          o_last  <= 6'(dcnt) == 6'(LAST_REP);
          if (!d_last) dcnt <= dcnt + 1'b1;
          after <= d_last ? ST_IDLE : ST_TRD;
          if (6'(dcnt) < 6'(MAX_REPORTS)) begin
            state <= ST_SEND;
          end else begin
            state <= d_last ? ST_IDLE : ST_TRD;
          end
        end
        ST_SEND: begin
          if (m_tready) state <= after;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: sv/nst_ram.sv
// Generic single-write, registered-read RAM
module nst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/nst_cfg.sv
// Configuration register file with APB access and range clamping
module nst_cfg
  import nst_pkg::*;
#(
  parameter int NUM_DYNAMIC = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  localparam logic [3:0] MAXD_HI = 4'((NUM_DYNAMIC < 15) ? NUM_DYNAMIC : 15);

  logic                      wr;
  logic signed [DEPTH_W-1:0] wd_depth;
  logic [15:0]               wd_ms;
  logic [Q_W-1:0]            wd_q;
  logic [3:0]                wd_maxd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    wd_depth = pwdata[DEPTH_W-1:0];
    if (wd_depth < DEPTH_LO) wd_depth = DEPTH_LO;
    else if (wd_depth > DEPTH_HI) wd_depth = DEPTH_HI;
    wd_ms = (pwdata[15:0] < MS_LO) ? MS_LO : pwdata[15:0];
    wd_q  = pwdata[Q_W-1:0];
    if (wd_q < Q_LO) wd_q = Q_LO;
    else if (wd_q > Q_HI) wd_q = Q_HI;
    wd_maxd = pwdata[3:0];
    if (wd_maxd < 4'd1) wd_maxd = 4'd1;
    else if (wd_maxd > MAXD_HI) wd_maxd = MAXD_HI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.notch_depth <= -14'sd3072;
      cfg.hold_ms     <= 16'd1000;
      cfg.release_ms  <= 16'd1000;
      cfg.notch_q     <= 9'd240;
      cfg.max_dynamic <= MAXD_HI < 4'd8 ? MAXD_HI : 4'd8;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_DEPTH:   cfg.notch_depth <= wd_depth;
        REG_HOLD:    cfg.hold_ms     <= wd_ms;
        REG_RELEASE: cfg.release_ms  <= wd_ms;
        REG_Q:       cfg.notch_q     <= wd_q;
        REG_MAXDYN:  cfg.max_dynamic <= wd_maxd;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DEPTH:   prdata = 32'(cfg.notch_depth);
      REG_HOLD:    prdata = 32'(cfg.hold_ms);
      REG_RELEASE: prdata = 32'(cfg.release_ms);
      REG_Q:       prdata = 32'(cfg.notch_q);
      REG_MAXDYN:  prdata = 32'(cfg.max_dynamic);
      default:     prdata = '0;
    endcase
  end
endmodule

// File: sv/nst_div.sv
// Release step unit: registered multiply, then restoring divide one bit a cycle
module nst_div
  import nst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MAG_W-1:0]   mag,
  input  logic [DELTA_W-1:0] delta,
  input  logic [15:0]        den,
  output logic               done,
  output logic [PROD_W-1:0]  quo
);
  localparam logic D_IDLE = 1'b0;
  localparam logic D_RUN  = 1'b1;

  logic                state;
  logic [PROD_W-1:0]   num;
  logic [15:0]         rem;
  logic [15:0]         den_r;
  logic [4:0]          cnt;
  logic [16:0]         trial;
  logic                qbit;

  assign trial = {rem, num[PROD_W-1]};
  assign qbit  = trial >= {1'b0, den_r};
  assign quo   = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            num   <= PROD_W'(mag) * PROD_W'(delta);
            den_r <= den;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= qbit ? 16'(trial - {1'b0, den_r}) : trial[15:0];
          num <= {num[PROD_W-2:0], qbit};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(PROD_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule

// File: sv/nst_checker.sv
// Port-level checker for the notch slot tracker, bound to the top level
`include "notch_slot_tracker_assert.svh"
module nst_checker
  import nst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);
  `NST_ASSERT_NOW(a_one_at_a_time, m_tvalid, !s_tready, "input taken while result pending")
  `NST_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `NST_ASSERT_NOW(a_event_code, m_tvalid, m_tuser <= EV_REJECTED, "event code out of range")
  `NST_ASSERT_NOW(a_reject_form, m_tvalid && (m_tuser == EV_REJECTED), m_tlast && (m_tdata[63:4] == '0), "rejected result malformed")
endmodule

bind notch_slot_tracker nst_checker u_nst_checker (.*);
